// File: design/mck_pkg.sv
`timescale 1ns / 1ps

package mck_pkg;

  localparam int TABLE_LEN = 41;
  localparam int TAB_IDX_W = 6;
  localparam int TICK_W    = 16;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_UNIT      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INTERCHAR = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_INTERWORD = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_FINAL     = 2'd3;

  localparam logic [TICK_W-1:0] UNIT_RST      = 16'd100;
  localparam logic [TICK_W-1:0] INTERCHAR_RST = 16'd200;
  localparam logic [TICK_W-1:0] INTERWORD_RST = 16'd700;
  localparam logic [TICK_W-1:0] FINAL_RST     = 16'd1000;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic              line_level;
    logic [TICK_W-1:0] hold_ticks;
    logic              last_of_char;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FIND,
    ST_BITS,
    ST_REST,
    ST_SPACE,
    ST_FINAL
  } state_t;

  function automatic logic [7:0] sym_char(input logic [TAB_IDX_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      6'd0:  c = "0";
      6'd1:  c = "1";
      6'd2:  c = "2";
      6'd3:  c = "3";
      6'd4:  c = "4";
      6'd5:  c = "5";
      6'd6:  c = "6";
      6'd7:  c = "7";
      6'd8:  c = "8";
      6'd9:  c = "9";
      6'd10: c = "A";
      6'd11: c = "B";
      6'd12: c = "C";
      6'd13: c = "D";
      6'd14: c = "E";
      6'd15: c = "F";
      6'd16: c = "G";
      6'd17: c = "H";
      6'd18: c = "I";
      6'd19: c = "J";
      6'd20: c = "K";
      6'd21: c = "L";
      6'd22: c = "M";
      6'd23: c = "N";
      6'd24: c = "O";
      6'd25: c = "P";
      6'd26: c = "Q";
      6'd27: c = "R";
      6'd28: c = "S";
      6'd29: c = "T";
      6'd30: c = "U";
      6'd31: c = "V";
      6'd32: c = "W";
      6'd33: c = "X";
      6'd34: c = "Y";
      6'd35: c = "Z";
      6'd36: c = ".";
      6'd37: c = ",";
      6'd38: c = "?";
      6'd39: c = "-";
      6'd40: c = " ";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // dot = 10, dash = 1110
  function automatic logic [31:0] sym_code(input logic [TAB_IDX_W-1:0] idx);
    logic [31:0] p;
    case (idx)
      6'd0:  p = 32'hEEEEE;
      6'd1:  p = 32'h2EEEE;
      6'd2:  p = 32'hAEEE;
      6'd3:  p = 32'h2AEE;
      6'd4:  p = 32'hAAE;
      6'd5:  p = 32'h2AA;
      6'd6:  p = 32'hEAA;
      6'd7:  p = 32'h3BAA;
      6'd8:  p = 32'hEEEA;
      6'd9:  p = 32'h3BBBA;
      6'd10: p = 32'h2E;
      6'd11: p = 32'h3AA;
      6'd12: p = 32'hEBA;
      6'd13: p = 32'hEA;
      6'd14: p = 32'h2;
      6'd15: p = 32'h2BA;
      6'd16: p = 32'h3BA;
      6'd17: p = 32'hAA;
      6'd18: p = 32'hA;
      6'd19: p = 32'h2EEE;
      6'd20: p = 32'h3AE;
      6'd21: p = 32'h2EA;
      6'd22: p = 32'hEE;
      6'd23: p = 32'h3A;
      6'd24: p = 32'hEEE;
      6'd25: p = 32'hBBA;
      6'd26: p = 32'h3BAE;
      6'd27: p = 32'hBA;
      6'd28: p = 32'h2A;
      6'd29: p = 32'hE;
      6'd30: p = 32'hAE;
      6'd31: p = 32'h2AE;
      6'd32: p = 32'h2EE;
      6'd33: p = 32'hEAE;
      6'd34: p = 32'h3AEE;
      6'd35: p = 32'hEEA;
      6'd36: p = 32'h2EBAE;
      6'd37: p = 32'hEEAEE;
      6'd38: p = 32'hAEEA;
      6'd39: p = 32'hEAAE;
      default: p = 32'h0;
    endcase
    return p;
  endfunction

endpackage

// File: design/mck_out_reg.sv
`timescale 1ns / 1ps

module mck_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mck_pkg::out_t push_data,
  output logic          space,
  output logic          out_valid,
  input  logic          out_ready,
  output mck_pkg::out_t out_data
);
  import mck_pkg::*;

  logic full;
  out_t data;

  assign space     = !full || out_ready;
  assign out_valid = full;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push) begin
      full <= 1'b1;
    end else if (out_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data <= push_data;
    end
  end

endmodule

// File: design/morse_char_keyer.sv
`timescale 1ns / 1ps

// channel  dir  handshake               payload
// in       in   in_valid / in_ready     in_data   (char_code, end_of_message)
// out      out  out_valid / out_ready   out_data  (line_level, hold_ticks, last_of_char)
// cfg      in   cfg_we                  cfg_index, cfg_data
//
// One character: an accept, a table compare scan of up to min(ALPHABET_SIZE,41) entries,
// a shift search for the leading one, then one beat per cycle while the output has space.
// A single shift register serves the search and the beats; in_ready is high only when idle.
// Output stalls hold the sequencer; the output register lets the last beat wait while idle.
// Reset is synchronous; registers return to 100/200/700/1000.

module morse_char_keyer #(
  parameter int CODE_BITS     = 24,
  parameter int ALPHABET_SIZE = 41
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mck_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mck_pkg::out_t               out_data,
  input  logic                        cfg_we,
  input  logic [mck_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [mck_pkg::TICK_W-1:0]  cfg_data
);
  import mck_pkg::*;

  localparam int LOOK_N = (ALPHABET_SIZE < TABLE_LEN) ? ALPHABET_SIZE : TABLE_LEN;
  localparam int IDX_W  = (LOOK_N > 1) ? $clog2(LOOK_N) : 1;
  localparam int PAT_W  = CODE_BITS - 1;
  localparam int POS_W  = $clog2(PAT_W);

  logic [TICK_W-1:0] unit_ticks;
  logic [TICK_W-1:0] interchar_rest_ticks;
  logic [TICK_W-1:0] interword_ticks;
  logic [TICK_W-1:0] final_ticks;

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [PAT_W-1:0] pat, pat_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [7:0]       ch, ch_next;
  logic             eom, eom_next;

  logic        push;
  out_t        push_data;
  logic        space;
  logic [31:0] code_word;
  logic        hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks           <= UNIT_RST;
      interchar_rest_ticks <= INTERCHAR_RST;
      interword_ticks      <= INTERWORD_RST;
      final_ticks          <= FINAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UNIT:      unit_ticks           <= cfg_data;
        REG_INTERCHAR: interchar_rest_ticks <= cfg_data;
        REG_INTERWORD: interword_ticks      <= cfg_data;
        REG_FINAL:     final_ticks          <= cfg_data;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    pat <= pat_next;
    pos <= pos_next;
    ch  <= ch_next;
    eom <= eom_next;
  end

  assign hit      = (sym_char(TAB_IDX_W'(idx)) == ch);
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    pat_next   = pat;
    pos_next   = pos;
    ch_next    = ch;
    eom_next   = eom;
    push       = 1'b0;
    push_data  = '0;
    code_word  = sym_code(TAB_IDX_W'(idx));
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ch_next    = in_data.char_code;
          eom_next   = in_data.end_of_message;
          idx_next   = '0;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (hit || idx == IDX_W'(LOOK_N - 1)) begin
          if (!hit) begin
            code_word = sym_code('0);
          end
          pat_next   = code_word[PAT_W-1:0];
          pos_next   = POS_W'(PAT_W - 1);
          state_next = ST_FIND;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_FIND: begin
        if (pat[PAT_W-1]) begin
          state_next = ST_BITS;
        end else if (pos == '0) begin
          state_next = ST_SPACE;
        end else begin
          pat_next = {pat[PAT_W-2:0], 1'b0};
          pos_next = pos - 1'b1;
        end
      end
      ST_BITS: begin
        if (space) begin
          push                 = 1'b1;
          push_data.line_level = pat[PAT_W-1];
          push_data.hold_ticks = unit_ticks;
          pat_next             = {pat[PAT_W-2:0], 1'b0};
          if (pos == '0) begin
            state_next = ST_REST;
          end else begin
            pos_next = pos - 1'b1;
          end
        end
      end
      ST_REST, ST_SPACE: begin
        if (space) begin
          push                   = 1'b1;
          push_data.hold_ticks   = (state == ST_REST) ? interchar_rest_ticks
                                                      : interword_ticks;
          push_data.last_of_char = !eom;
          state_next             = eom ? ST_FINAL : ST_IDLE;
        end
      end
      ST_FINAL: begin
        if (space) begin
          push                   = 1'b1;
          push_data.hold_ticks   = final_ticks;
          push_data.last_of_char = 1'b1;
          state_next             = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  mck_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: dv/mck_checker.sv
`timescale 1ns / 1ps

module mck_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  mck_pkg::in_t                  in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  mck_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [mck_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [mck_pkg::TICK_W-1:0]    cfg_data,
  output int                            fail_count,
  output int                            beats_pending
);
  import mck_pkg::*;

  localparam int SCAN_TOP = 22;

  logic [TICK_W-1:0] unit_q;
  logic [TICK_W-1:0] rest_q;
  logic [TICK_W-1:0] word_q;
  logic [TICK_W-1:0] final_q;

  out_t beats_due[$];

  // dot = 10, dash = 1110; unknown codes key as '0'
  function automatic logic [23:0] pattern_of(input logic [7:0] c);
    logic [23:0] p;
    case (c)
      "0": p = 24'hEEEEE;
      "1": p = 24'h2EEEE;
      "2": p = 24'hAEEE;
      "3": p = 24'h2AEE;
      "4": p = 24'hAAE;
      "5": p = 24'h2AA;
      "6": p = 24'hEAA;
      "7": p = 24'h3BAA;
      "8": p = 24'hEEEA;
      "9": p = 24'h3BBBA;
      "A": p = 24'h2E;
      "B": p = 24'h3AA;
      "C": p = 24'hEBA;
      "D": p = 24'hEA;
      "E": p = 24'h2;
      "F": p = 24'h2BA;
      "G": p = 24'h3BA;
      "H": p = 24'hAA;
      "I": p = 24'hA;
      "J": p = 24'h2EEE;
      "K": p = 24'h3AE;
      "L": p = 24'h2EA;
      "M": p = 24'hEE;
      "N": p = 24'h3A;
      "O": p = 24'hEEE;
      "P": p = 24'hBBA;
      "Q": p = 24'h3BAE;
      "R": p = 24'hBA;
      "S": p = 24'h2A;
      "T": p = 24'hE;
      "U": p = 24'hAE;
      "V": p = 24'h2AE;
      "W": p = 24'h2EE;
      "X": p = 24'hEAE;
      "Y": p = 24'h3AEE;
      "Z": p = 24'hEEA;
      ".": p = 24'h2EBAE;
      ",": p = 24'hEEAEE;
      "?": p = 24'hAEEA;
      "-": p = 24'hEAAE;
      " ": p = 24'h0;
      default: p = 24'hEEEEE;
    endcase
    return p;
  endfunction

  task automatic push_beat(input logic lvl, input logic [TICK_W-1:0] ticks);
    out_t b;
    b.line_level   = lvl;
    b.hold_ticks   = ticks;
    b.last_of_char = 1'b0;
    beats_due.push_back(b);
  endtask

  task automatic key_char(input in_t d);
    logic [23:0] pat;
    int          lead;
    int          b;
    pat  = pattern_of(d.char_code);
    lead = -1;
    for (b = SCAN_TOP; b >= 0; b--)
      if (pat[b] && lead < 0) lead = b;
    if (lead < 0) begin
      push_beat(1'b0, word_q);
    end else begin
      for (b = lead; b >= 0; b--) push_beat(pat[b], unit_q);
      push_beat(1'b0, rest_q);
    end
    if (d.end_of_message) push_beat(1'b0, final_q);
    beats_due[beats_due.size()-1].last_of_char = 1'b1;
  endtask

  task automatic note_fail(input string what, input out_t exp_b, input out_t got_b);
    if (fail_count < 10)
      $display("%0t %s: exp level=%0b ticks=%0d last=%0b, got level=%0b ticks=%0d last=%0b",
               $realtime, what, exp_b.line_level, exp_b.hold_ticks, exp_b.last_of_char,
               got_b.line_level, got_b.hold_ticks, got_b.last_of_char);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_t exp_b;
    if (rst) begin
      unit_q  = UNIT_RST;
      rest_q  = INTERCHAR_RST;
      word_q  = INTERWORD_RST;
      final_q = FINAL_RST;
      beats_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (beats_due.size() == 0) begin
          exp_b = '0;
          note_fail("unexpected beat", exp_b, out_data);
        end else begin
          exp_b = beats_due.pop_front();
          if (out_data.line_level !== exp_b.line_level ||
              out_data.hold_ticks !== exp_b.hold_ticks ||
              out_data.last_of_char !== exp_b.last_of_char)
            note_fail("beat mismatch", exp_b, out_data);
        end
      end
      if (in_valid && in_ready) key_char(in_data);
      if (cfg_we) begin
        case (cfg_index)
          REG_UNIT:      unit_q  = cfg_data;
          REG_INTERCHAR: rest_q  = cfg_data;
          REG_INTERWORD: word_q  = cfg_data;
          REG_FINAL:     final_q = cfg_data;
          default: ;
        endcase
      end
    end
    beats_pending = beats_due.size();
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import mck_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_t                 out_data;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [TICK_W-1:0]    cfg_data;
  int                   fail_count;
  int                   beats_pending;
  logic                 steady;
  int                   cyc;

  string glyphs = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ.,?- ";

  morse_char_keyer i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mck_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .beats_pending (beats_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("tb: FAIL");
    $finish;
  end

  // receiver: random stall before each beat, none in the steady phase
  initial begin
    int gap;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_char(input logic [7:0] c, input logic eom);
    int  gap;
    in_t d;
    d.char_code      = c;
    d.end_of_message = eom;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_random;
    logic [7:0] c;
    if ($urandom_range(0, 9) < 7) c = glyphs[$urandom_range(0, 40)];
    else c = 8'($urandom_range(0, 255));
    send_char(c, $urandom_range(0, 7) == 0);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (beats_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_regs(input logic [TICK_W-1:0] unit_v, input logic [TICK_W-1:0] rest_v,
                            input logic [TICK_W-1:0] word_v, input logic [TICK_W-1:0] fin_v);
    cfg_we    <= 1'b1;
    cfg_index <= REG_UNIT;
    cfg_data  <= unit_v;
    @(negedge clk);
    cfg_index <= REG_INTERCHAR;
    cfg_data  <= rest_v;
    @(negedge clk);
    cfg_index <= REG_INTERWORD;
    cfg_data  <= word_v;
    @(negedge clk);
    cfg_index <= REG_FINAL;
    cfg_data  <= fin_v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_UNIT;
    cfg_data  = '0;
    steady    = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset register values
    send_char("0", 1'b1);
    send_char("E", 1'b0);
    send_char("T", 1'b0);
    send_char(" ", 1'b0);
    send_char(" ", 1'b1);
    send_char("5", 1'b0);
    send_char(".", 1'b0);
    send_char(",", 1'b0);
    send_char("?", 1'b0);
    send_char("-", 1'b0);
    send_char("a", 1'b0);
    send_char("z", 1'b1);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char("Z", 1'b0);
    send_char("9", 1'b0);
    send_char("M", 1'b1);
    send_char("Q", 1'b0);

    for (int ph = 1; ph <= 5; ph++) begin
      drain();
      case (ph)
        1: write_regs(16'd1, 16'd0, 16'd0, 16'd0);
        2: write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: write_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      endcase
      steady = (ph == 4);
      if (ph == 2) begin
        send_char(" ", 1'b1);
        send_char("0", 1'b1);
      end
      for (int n = 0; n < 42; n++) begin
        send_random();
        // hold off the sender until the output side is empty
        if (ph == 3 && n == 20) drain();
      end
    end

    drain();
    repeat (40) @(negedge clk);
    if (fail_count == 0 && beats_pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
